### hdl/drive_controlword_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// drive_controlword_sequencer_top_assert.svh
// Assertion macros shared by the sequencer RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DRIVE_CONTROLWORD_SEQUENCER_TOP_ASSERT_SVH
`define DRIVE_CONTROLWORD_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DCS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("dcs assertion failed");

// next-cycle implication
`define DCS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("dcs assertion failed");

`else

`define DCS_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define DCS_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

### hdl/dcs_pkg.sv
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared constants and types of the drive control word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_RESET_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RECIP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_RESET_DLY = 3'd4;

  localparam int SCALE_W = 24;
  localparam int TIME_W  = 27;

  localparam logic signed [SCALE_W-1:0] Q16_ONE       = 24'sd65536;
  localparam logic [TIME_W-1:0]         TICK_RST      = 27'd1000000;
  localparam logic [TIME_W-1:0]         AUTO_DLY_RST  = 27'd100000000;
  localparam logic signed [7:0]         VELOCITY_MODE = 8'sd2;
  localparam logic signed [31:0]        RAW_LIMIT     = 32'sd32767;

  // status flag bit positions
  localparam int FLAG_READY = 0;
  localparam int FLAG_ON    = 1;
  localparam int FLAG_OP    = 2;
  localparam int FLAG_FAULT = 3;

  // control word bit positions
  localparam int CW_SWITCH_ON   = 0;
  localparam int CW_ENABLE_VOLT = 1;
  localparam int CW_QUICK_STOP  = 2;
  localparam int CW_ENABLE_OP   = 3;
  localparam int CW_FAULT_RESET = 7;
  localparam int CW_HALT        = 8;

  typedef struct packed {
    logic [15:0] control_word;
    logic [9:0]  status_flags;
  } ctrl_res_t;

endpackage

`default_nettype wire

### hdl/dcs_ctrl.sv
// ----------------------------------------------------------------------------
// dcs_ctrl
// Status decode, fault masking countdown and control word build.
// ----------------------------------------------------------------------------
`default_nettype none
`include "drive_controlword_sequencer_top_assert.svh"

module dcs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [15:0]                 status_word,
  input  logic signed [7:0]           mode_display,
  input  logic                        link_operational,
  input  logic                        enable_request,
  input  logic                        fault_reset_request,
  input  logic                        halt_request,
  input  logic                        auto_reset_enable,
  input  logic [dcs_pkg::TIME_W-1:0]  tick_period_ns,
  input  logic [dcs_pkg::TIME_W-1:0]  auto_reset_delay_ns,
  output dcs_pkg::ctrl_res_t          res
);
  import dcs_pkg::*;

  logic              en_prev_r, en_prev_nxt;
  logic [TIME_W-1:0] mask_r, mask_nxt;
  logic              drive_fault;
  logic              masked;
  logic              fault;
  logic              en_rise;
  logic              auto_fire;
  logic [9:0]        flags;
  logic [15:0]       ctl;

  assign drive_fault = status_word[3] | (mode_display != VELOCITY_MODE);
  assign masked      = link_operational && (mask_r != '0);
  assign en_rise     = enable_request && !en_prev_r;
  assign auto_fire   = fault && auto_reset_enable && en_rise;

  always_comb begin
    if (!link_operational) begin
      fault = 1'b1;
    end else if (masked) begin
      fault = 1'b0;
    end else begin
      fault = drive_fault;
    end
  end

  always_comb begin
    flags = '0;
    if (link_operational) begin
      flags = {status_word[10:9], status_word[7:4], 1'b0, status_word[2:0]};
    end
    flags[FLAG_FAULT] = fault;
  end

  always_comb begin
    ctl = '0;
    ctl[CW_QUICK_STOP] = !fault_reset_request;
    if (fault) begin
      ctl[CW_FAULT_RESET] = fault_reset_request | auto_fire;
    end else begin
      ctl[CW_ENABLE_VOLT] = enable_request;
      ctl[CW_SWITCH_ON]   = enable_request & flags[FLAG_READY];
      ctl[CW_ENABLE_OP]   = enable_request & flags[FLAG_READY] & flags[FLAG_ON];
      if (flags[FLAG_OP]) begin
        ctl[6:4] = 3'b111;
      end
    end
    ctl[CW_HALT] = halt_request;
  end

  always_comb begin
    mask_nxt    = mask_r;
    en_prev_nxt = enable_request;
    if (masked) begin
      // count saturates at zero
      mask_nxt = (mask_r > tick_period_ns) ? (mask_r - tick_period_ns) : '0;
    end
    if (auto_fire) begin
      mask_nxt = auto_reset_delay_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_prev_r <= 1'b0;
      mask_r    <= '0;
    end else if (step) begin
      en_prev_r <= en_prev_nxt;
      mask_r    <= mask_nxt;
    end
  end

  assign res = '{control_word: ctl, status_flags: flags};

  `DCS_ASSERT_NOW(a_mask_hides_fault, clk, rst_n, masked, !res.status_flags[FLAG_FAULT])
  `DCS_ASSERT_NOW(a_link_down_flags, clk, rst_n, !link_operational, res.status_flags == 10'h008)
  `DCS_ASSERT_NEXT(a_mask_no_grow, clk, rst_n, step && masked, mask_r <= $past(mask_r))

endmodule

`default_nettype wire

### hdl/dcs_speed.sv
// ----------------------------------------------------------------------------
// dcs_speed
// Speed scaling: product register, then truncation, saturation and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_speed (
  input  logic                               clk,
  input  logic                               step,
  input  logic signed [31:0]                 speed_command,
  input  logic signed [15:0]                 speed_feedback_raw,
  input  logic                               link_operational,
  input  logic signed [dcs_pkg::SCALE_W-1:0] speed_scale,
  input  logic signed [dcs_pkg::SCALE_W-1:0] speed_scale_recip,
  output logic signed [15:0]                 speed_target_raw,
  output logic signed [31:0]                 speed_feedback_rpm,
  output logic [30:0]                        speed_feedback_abs
);
  import dcs_pkg::*;

  logic signed [SCALE_W-1:0] scale_eff;
  logic signed [SCALE_W-1:0] recip_eff;
  logic signed [55:0]        cmd_prod_nxt, cmd_prod_r;
  logic signed [39:0]        fb_prod_nxt, fb_prod_r;
  logic signed [55:0]        cmd_adj;
  logic signed [39:0]        fb_adj;
  logic signed [31:0]        target_full;
  logic [31:0]               rpm_mag;

  // zero scale acts as unity for both directions
  assign scale_eff = (speed_scale == '0) ? Q16_ONE : speed_scale;
  assign recip_eff = (speed_scale == '0) ? Q16_ONE : speed_scale_recip;

  assign cmd_prod_nxt = speed_command * scale_eff;
  assign fb_prod_nxt  = link_operational ? (speed_feedback_raw * recip_eff) : 40'sd0;

  always_ff @(posedge clk) begin
    if (step) begin
      cmd_prod_r <= cmd_prod_nxt;
      fb_prod_r  <= fb_prod_nxt;
    end
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  assign cmd_adj     = cmd_prod_r + (cmd_prod_r[55] ? 56'sd16777215 : 56'sd0);
  assign target_full = cmd_adj[55:24];
  assign fb_adj      = fb_prod_r + (fb_prod_r[39] ? 40'sd255 : 40'sd0);

  always_comb begin
    if (target_full > RAW_LIMIT) begin
      speed_target_raw = RAW_LIMIT[15:0];
    end else if (target_full < -RAW_LIMIT) begin
      speed_target_raw = 16'(-RAW_LIMIT);
    end else begin
      speed_target_raw = target_full[15:0];
    end
  end

  assign speed_feedback_rpm = fb_adj[39:8];
  assign rpm_mag            = speed_feedback_rpm[31] ? (~speed_feedback_rpm + 32'sd1)
                                                     : speed_feedback_rpm;
  assign speed_feedback_abs = rpm_mag[30:0];

endmodule

`default_nettype wire

### hdl/drive_controlword_sequencer_top.sv
// ----------------------------------------------------------------------------
// drive_controlword_sequencer_top
// Velocity-mode control word sequencer: one servo cycle word in, one out.
// ----------------------------------------------------------------------------
// Usage:
//   Input word (in_*): one servo cycle of drive feedback and host requests,
//   taken at a clock edge with in_valid high and in_stall low.
//   Output word (out_*): control word, scaled speed target, status flags,
//   scaled feedback and pass-through codes, taken with out_valid high and
//   out_stall low.
//   Config (cfg_*): cfg_we writes cfg_wdata to register cfg_index; write only
//   while no word is in flight.
//   The word passes through three register stages (input, product,
//   output) before out_valid rises. Throughput: one word per cycle while
//   out_stall is low.
//   A stalled output holds its word; bubbles close up, and in_stall rises
//   only once all three stages are full and out_stall is high.
//   Reset: pipeline empties, registers return to their defaults, the enable
//   edge detector and the fault masking countdown clear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "drive_controlword_sequencer_top_assert.svh"

module drive_controlword_sequencer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [dcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    in_status_word,
  input  logic signed [15:0]             in_speed_feedback_raw,
  input  logic signed [7:0]              in_mode_display,
  input  logic [15:0]                    in_current_raw,
  input  logic [15:0]                    in_warn_error_raw,
  input  logic [15:0]                    in_temperature_raw,
  input  logic                           in_link_operational,
  input  logic                           in_enable_request,
  input  logic                           in_fault_reset_request,
  input  logic                           in_halt_request,
  input  logic signed [31:0]             in_speed_command,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_control_word,
  output logic signed [15:0]             out_speed_target_raw,
  output logic [9:0]                     out_status_flags,
  output logic signed [31:0]             out_speed_feedback_rpm,
  output logic [30:0]                    out_speed_feedback_abs,
  output logic [7:0]                     out_drive_err_code,
  output logic [7:0]                     out_warning_code,
  output logic [15:0]                    out_current_centiamps,
  output logic [15:0]                    out_temperature_decidegrees
);
  import dcs_pkg::*;

  // configuration registers
  logic                      auto_reset_enable_r;
  logic signed [SCALE_W-1:0] speed_scale_r;
  logic signed [SCALE_W-1:0] speed_scale_recip_r;
  logic [TIME_W-1:0]         tick_period_ns_r;
  logic [TIME_W-1:0]         auto_reset_delay_ns_r;

  // handshake
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_adv, s2_adv, s1_adv;
  logic in_take, s1_step, s2_step;

  // stage 1: input word
  logic [15:0]        s1_status_word_r;
  logic signed [15:0] s1_fb_raw_r;
  logic signed [7:0]  s1_mode_r;
  logic [15:0]        s1_current_r;
  logic [15:0]        s1_warn_error_r;
  logic [15:0]        s1_temp_r;
  logic               s1_link_r;
  logic               s1_enable_r;
  logic               s1_fault_reset_r;
  logic               s1_halt_r;
  logic signed [31:0] s1_cmd_r;

  // stage 2: decoded control, pass-through
  ctrl_res_t   ctrl_res;
  ctrl_res_t   s2_ctrl_r;
  logic [15:0] s2_current_r;
  logic [15:0] s2_warn_error_r;
  logic [15:0] s2_temp_r;

  logic signed [15:0] speed_target;
  logic signed [31:0] fb_rpm;
  logic [30:0]        fb_abs;

  // output word
  ctrl_res_t          out_ctrl_r;
  logic signed [15:0] out_target_r;
  logic signed [31:0] out_rpm_r;
  logic [30:0]        out_abs_r;
  logic [15:0]        out_current_r;
  logic [15:0]        out_warn_error_r;
  logic [15:0]        out_temp_r;

  logic fault_rst_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_reset_enable_r   <= 1'b1;
      speed_scale_r         <= Q16_ONE;
      speed_scale_recip_r   <= Q16_ONE;
      tick_period_ns_r      <= TICK_RST;
      auto_reset_delay_ns_r <= AUTO_DLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AUTO_RESET_EN:  auto_reset_enable_r   <= cfg_wdata[0];
        REG_SPEED_SCALE:    speed_scale_r         <= cfg_wdata[SCALE_W-1:0];
        REG_SCALE_RECIP:    speed_scale_recip_r   <= cfg_wdata[SCALE_W-1:0];
        REG_TICK_PERIOD:    tick_period_ns_r      <= cfg_wdata[TIME_W-1:0];
        REG_AUTO_RESET_DLY: auto_reset_delay_ns_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the stage after it moves
  assign out_adv = !out_valid_r || !out_stall;
  assign s2_adv  = !s2_valid_r || out_adv;
  assign s1_adv  = !s1_valid_r || s2_adv;
  assign in_take = in_valid && s1_adv;
  assign s1_step = s1_valid_r && s2_adv;
  assign s2_step = s2_valid_r && out_adv;

  assign s1_valid_nxt  = s1_adv ? in_valid : s1_valid_r;
  assign s2_valid_nxt  = s2_adv ? s1_valid_r : s2_valid_r;
  assign out_valid_nxt = out_adv ? s2_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_status_word_r <= in_status_word;
      s1_fb_raw_r      <= in_speed_feedback_raw;
      s1_mode_r        <= in_mode_display;
      s1_current_r     <= in_current_raw;
      s1_warn_error_r  <= in_warn_error_raw;
      s1_temp_r        <= in_temperature_raw;
      s1_link_r        <= in_link_operational;
      s1_enable_r      <= in_enable_request;
      s1_fault_reset_r <= in_fault_reset_request;
      s1_halt_r        <= in_halt_request;
      s1_cmd_r         <= in_speed_command;
    end
  end

  dcs_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .step                (s1_step),
    .status_word         (s1_status_word_r),
    .mode_display        (s1_mode_r),
    .link_operational    (s1_link_r),
    .enable_request      (s1_enable_r),
    .fault_reset_request (s1_fault_reset_r),
    .halt_request        (s1_halt_r),
    .auto_reset_enable   (auto_reset_enable_r),
    .tick_period_ns      (tick_period_ns_r),
    .auto_reset_delay_ns (auto_reset_delay_ns_r),
    .res                 (ctrl_res)
  );

  dcs_speed u_speed (
    .clk                (clk),
    .step               (s1_step),
    .speed_command      (s1_cmd_r),
    .speed_feedback_raw (s1_fb_raw_r),
    .link_operational   (s1_link_r),
    .speed_scale        (speed_scale_r),
    .speed_scale_recip  (speed_scale_recip_r),
    .speed_target_raw   (speed_target),
    .speed_feedback_rpm (fb_rpm),
    .speed_feedback_abs (fb_abs)
  );

  always_ff @(posedge clk) begin
    if (s1_step) begin
      s2_ctrl_r       <= ctrl_res;
      s2_current_r    <= s1_current_r;
      s2_warn_error_r <= s1_warn_error_r;
      s2_temp_r       <= s1_temp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_step) begin
      out_ctrl_r       <= s2_ctrl_r;
      out_target_r     <= speed_target;
      out_rpm_r        <= fb_rpm;
      out_abs_r        <= fb_abs;
      out_current_r    <= s2_current_r;
      out_warn_error_r <= s2_warn_error_r;
      out_temp_r       <= s2_temp_r;
    end
  end

  assign in_stall                    = !s1_adv;
  assign out_valid                   = out_valid_r;
  assign out_control_word            = out_ctrl_r.control_word;
  assign out_status_flags            = out_ctrl_r.status_flags;
  assign out_speed_target_raw        = out_target_r;
  assign out_speed_feedback_rpm      = out_rpm_r;
  assign out_speed_feedback_abs      = out_abs_r;
  assign out_drive_err_code          = out_warn_error_r[7:0];
  assign out_warning_code            = out_warn_error_r[15:8];
  assign out_current_centiamps       = out_current_r;
  assign out_temperature_decidegrees = out_temp_r;

  // fault reset bit only goes out with the fault flag
  assign fault_rst_ok = !out_control_word[CW_FAULT_RESET] || out_status_flags[FLAG_FAULT];

  `DCS_ASSERT_NEXT(a_take_fills_s1, clk, rst_n, in_take, s1_valid_r)
  `DCS_ASSERT_NOW(a_reset_needs_fault, clk, rst_n, out_valid_r, fault_rst_ok)
  `DCS_ASSERT_NOW(a_target_in_range, clk, rst_n, out_valid_r, out_speed_target_raw != 16'sh8000)

endmodule

`default_nettype wire
